// File: hdl/cpd_pkg.sv
// cpd_pkg: shared types, constants and the CRC16 byte update for the packet deframer.
// No dependencies; imported by cpd_regs and crc16_packet_deframer_unit.
`timescale 1ns / 1ps
package cpd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned ADDR_W   = 3;

  localparam logic [CRC_W-1:0] CRC_POLY   = 16'h1021;
  localparam logic [CRC_W-1:0] CRC_TOPBIT = 16'h8000;

  localparam logic [PHASE_W-1:0] PH_HUNT   = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LEN    = 3'd1;
  localparam logic [PHASE_W-1:0] PH_DATA   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CRC_HI = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CRC_LO = 3'd4;
  localparam logic [PHASE_W-1:0] PH_END    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_END = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CRC = 2'd2;

  localparam logic [BYTE_W-1:0] START_RESET = 8'd2;
  localparam logic [BYTE_W-1:0] END_RESET   = 8'd3;

  // register index taken from paddr bit 2
  localparam logic REG_START = 1'b0;
  localparam logic REG_END   = 1'b1;

  typedef struct packed {
    logic [BYTE_W-1:0] start_marker;
    logic [BYTE_W-1:0] end_marker;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   payload_byte;
    logic                frame_done;
    logic [STATUS_W-1:0] frame_status;
    logic [BYTE_W-1:0]   frame_length;
  } res_t;

  function automatic logic [CRC_W-1:0] crc_add_byte(
    input logic [CRC_W-1:0]  crc,
    input logic [BYTE_W-1:0] b
  );
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if ((c & CRC_TOPBIT) != '0) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/cpd_regs.sv
// cpd_regs: APB-style register block holding the start and end marker bytes.
// Depends on cpd_pkg.
`timescale 1ns / 1ps
module cpd_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cpd_pkg::ADDR_W-1:0] paddr,
  input  logic [cpd_pkg::DATA_W-1:0] pwdata,
  output logic [cpd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output cpd_pkg::cfg_t              cfg
);
  import cpd_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= START_RESET;
      cfg_r.end_marker   <= END_RESET;
    end else if (wr_en) begin
      if (paddr[2] == REG_START) begin
        cfg_r.start_marker <= pwdata[BYTE_W-1:0];
      end else begin
        cfg_r.end_marker <= pwdata[BYTE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_START) begin
      prdata[BYTE_W-1:0] = cfg_r.start_marker;
    end else begin
      prdata[BYTE_W-1:0] = cfg_r.end_marker;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: hdl/crc16_packet_deframer_unit.sv
// crc16_packet_deframer_unit: start/length/CRC16 packet deframer, top level.
// Each result is registered in the output register, or in the skid entry under a stall.
// Throughput: one byte per cycle while the skid entry is empty.
// The phase and byte-wide CRC update are combinational; a full skid entry drops in_ready.
// Reset: synchronous active-low rst_n; hunting for start, markers 2 and 3, CRC state zero.
// Depends on cpd_pkg and cpd_regs.
`timescale 1ns / 1ps
module crc16_packet_deframer_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [cpd_pkg::BYTE_W-1:0]   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cpd_pkg::BYTE_W-1:0]   out_payload_byte,
  output logic                         out_frame_done,
  output logic [cpd_pkg::STATUS_W-1:0] out_frame_status,
  output logic [cpd_pkg::BYTE_W-1:0]   out_frame_length,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [cpd_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [cpd_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [cpd_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import cpd_pkg::*;

  cfg_t cfg;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [BYTE_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [BYTE_W-1:0]  length_seen_r, length_seen_nxt;
  logic [CRC_W-1:0]   running_crc_r, running_crc_nxt;
  logic [CRC_W-1:0]   received_crc_r, received_crc_nxt;

  res_t res;
  logic has_res;
  logic accept;
  logic out_fire;

  res_t out_r, skid_r;
  logic out_v_r, skid_v_r;

  cpd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign in_ready = ~skid_v_r;
  assign accept   = in_valid & in_ready;
  assign out_fire = out_v_r & out_ready;

  always_comb begin
    phase_nxt        = phase_r;
    bytes_left_nxt   = bytes_left_r;
    length_seen_nxt  = length_seen_r;
    running_crc_nxt  = running_crc_r;
    received_crc_nxt = received_crc_r;
    has_res          = 1'b0;
    res              = '0;
    case (phase_r)
      PH_LEN: begin
        length_seen_nxt  = in_rx_byte;
        bytes_left_nxt   = in_rx_byte;
        running_crc_nxt  = '0;
        received_crc_nxt = '0;
        phase_nxt        = (in_rx_byte == '0) ? PH_CRC_HI : PH_DATA;
      end
      PH_DATA: begin
        running_crc_nxt  = crc_add_byte(running_crc_r, in_rx_byte);
        bytes_left_nxt   = bytes_left_r - BYTE_W'(1);
        if (bytes_left_nxt == '0) begin
          phase_nxt = PH_CRC_HI;
        end
        has_res          = 1'b1;
        res.payload_byte = in_rx_byte;
      end
      PH_CRC_HI: begin
        received_crc_nxt = {in_rx_byte, 8'h00};
        phase_nxt        = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        received_crc_nxt = {received_crc_r[CRC_W-1:BYTE_W], in_rx_byte};
        phase_nxt        = PH_END;
      end
      PH_END: begin
        has_res          = 1'b1;
        res.frame_done   = 1'b1;
        res.frame_length = length_seen_r;
        if (in_rx_byte != cfg.end_marker) begin
          res.frame_status = ST_BAD_END;
        end else if (received_crc_r != running_crc_r) begin
          res.frame_status = ST_BAD_CRC;
        end else begin
          res.frame_status = ST_OK;
        end
        phase_nxt = PH_HUNT;
      end
      default: begin
        phase_nxt = (in_rx_byte == cfg.start_marker) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      bytes_left_r   <= '0;
      length_seen_r  <= '0;
      running_crc_r  <= '0;
      received_crc_r <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      bytes_left_r   <= bytes_left_nxt;
      length_seen_r  <= length_seen_nxt;
      running_crc_r  <= running_crc_nxt;
      received_crc_r <= received_crc_nxt;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (accept && has_res) begin
      if (out_v_r && !out_fire) begin
        skid_v_r <= 1'b1;
      end else begin
        out_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (accept && has_res) begin
      if (out_v_r && !out_fire) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid        = out_v_r;
  assign out_payload_byte = out_r.payload_byte;
  assign out_frame_done   = out_r.frame_done;
  assign out_frame_status = out_r.frame_status;
  assign out_frame_length = out_r.frame_length;

endmodule

// File: tb/testbench.sv
// testbench: self-checking bench for crc16_packet_deframer_unit, byte stream in, results out.
// Holds a small scoreboard class that predicts payload and status transactions.
// Depends on cpd_pkg and the deframer RTL only.
`timescale 1ns / 1ps
module testbench;
  import cpd_pkg::*;

  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int IDLE_LIMIT    = 3000;
  localparam int PHASE_BYTES   = 120;
  localparam int LONGEST_LEN   = 255;

  localparam logic [ADDR_W-1:0] ADDR_START_MARKER = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_END_MARKER   = 3'd4;

  class deframer_scoreboard;
    logic [BYTE_W-1:0]  start_marker;
    logic [BYTE_W-1:0]  end_marker;
    logic [PHASE_W-1:0] phase;
    logic [BYTE_W-1:0]  bytes_left;
    logic [BYTE_W-1:0]  length_seen;
    logic [CRC_W-1:0]   running_crc;
    logic [CRC_W-1:0]   received_crc;
    res_t               expected_q[$];
    int                 error_count;

    function new();
      start_marker = START_RESET;
      end_marker   = END_RESET;
      phase        = PH_HUNT;
      bytes_left   = '0;
      length_seen  = '0;
      running_crc  = '0;
      received_crc = '0;
      error_count  = 0;
    endfunction

    // bit-serial form of the 0x1021 update, data MSB first
    static function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] crc, logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      logic             fb;
      c = crc;
      for (int i = BYTE_W - 1; i >= 0; i--) begin
        fb = c[CRC_W-1] ^ b[i];
        c  = {c[CRC_W-2:0], 1'b0};
        if (fb) c = c ^ CRC_POLY;
      end
      return c;
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      res_t r;
      r = '0;
      case (phase)
        PH_LEN: begin
          length_seen  = b;
          bytes_left   = b;
          running_crc  = '0;
          received_crc = '0;
          phase        = (b == 0) ? PH_CRC_HI : PH_DATA;
        end
        PH_DATA: begin
          running_crc = crc_step(running_crc, b);
          bytes_left  = bytes_left - BYTE_W'(1);
          if (bytes_left == 0) phase = PH_CRC_HI;
          r.payload_byte = b;
          r.frame_status = ST_OK;
          expected_q.push_back(r);
        end
        PH_CRC_HI: begin
          received_crc = {b, 8'h00};
          phase        = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          received_crc[7:0] = b;
          phase             = PH_END;
        end
        PH_END: begin
          // end byte is judged before the CRC
          if (b != end_marker) r.frame_status = ST_BAD_END;
          else if (received_crc != running_crc) r.frame_status = ST_BAD_CRC;
          else r.frame_status = ST_OK;
          r.frame_done   = 1'b1;
          r.frame_length = length_seen;
          phase          = PH_HUNT;
          expected_q.push_back(r);
        end
        default: begin
          phase = (b == start_marker) ? PH_LEN : PH_HUNT;
        end
      endcase
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: payload_byte %0h frame_done %0b",
               got.payload_byte, got.frame_done);
        error_count++;
        return;
      end
      want = expected_q.pop_front();
      if (got.payload_byte !== want.payload_byte) begin
        $error("payload_byte: expected %0h, actual %0h", want.payload_byte, got.payload_byte);
        error_count++;
      end
      if (got.frame_done !== want.frame_done) begin
        $error("frame_done: expected %0b, actual %0b", want.frame_done, got.frame_done);
        error_count++;
      end
      if (got.frame_status !== want.frame_status) begin
        $error("frame_status: expected %0d, actual %0d", want.frame_status, got.frame_status);
        error_count++;
      end
      if (got.frame_length !== want.frame_length) begin
        $error("frame_length: expected %0d, actual %0d", want.frame_length, got.frame_length);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [BYTE_W-1:0]   in_rx_byte;
  logic                out_valid;
  logic                out_ready;
  logic [BYTE_W-1:0]   out_payload_byte;
  logic                out_frame_done;
  logic [STATUS_W-1:0] out_frame_status;
  logic [BYTE_W-1:0]   out_frame_length;
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [ADDR_W-1:0]   cfg_paddr;
  logic [DATA_W-1:0]   cfg_pwdata;
  logic [DATA_W-1:0]   cfg_prdata;
  logic                cfg_pready;

  deframer_scoreboard sb = new();
  logic [BYTE_W-1:0]  tx_q[$];
  logic [BYTE_W-1:0]  cur_start = START_RESET;
  logic [BYTE_W-1:0]  cur_end   = END_RESET;
  bit                 hold_pending = 1'b0;
  int                 stalled_cycles = 0;

  crc16_packet_deframer_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_payload_byte (out_payload_byte),
    .out_frame_done   (out_frame_done),
    .out_frame_status (out_frame_status),
    .out_frame_length (out_frame_length),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // transaction monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(res_t'({out_payload_byte, out_frame_done, out_frame_status,
                                out_frame_length}));
      if (in_valid && in_ready) sb.note_byte(in_rx_byte);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled_cycles = 0;
      else stalled_cycles++;
      if (stalled_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: runs of always-ready, light and heavy back-pressure, one long hold-off
  initial begin
    int mode;
    int run_len;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode    = $urandom_range(0, 2);
      run_len = $urandom_range(16, 200);
      while (run_len > 0 && !hold_pending) begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk);
        run_len--;
      end
    end
  end

  function automatic int pick_burst();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 20);
  endfunction

  function automatic void add_frame(input logic [BYTE_W-1:0] payload[$],
                                    input logic [CRC_W-1:0] crc_xor,
                                    input logic [BYTE_W-1:0] end_xor);
    logic [CRC_W-1:0] crc;
    crc = '0;
    tx_q.push_back(cur_start);
    tx_q.push_back(BYTE_W'(payload.size()));
    foreach (payload[i]) begin
      crc = deframer_scoreboard::crc_step(crc, payload[i]);
      tx_q.push_back(payload[i]);
    end
    crc = crc ^ crc_xor;
    tx_q.push_back(crc[15:8]);
    tx_q.push_back(crc[7:0]);
    tx_q.push_back(cur_end ^ end_xor);
  endfunction

  // mostly well-formed frames; some noise, truncated frames and corrupted trailers
  function automatic void add_random_traffic(int unsigned target);
    logic [BYTE_W-1:0] payload[$];
    logic [BYTE_W-1:0] b;
    logic [CRC_W-1:0]  crc_xor;
    logic [BYTE_W-1:0] end_xor;
    int unsigned       pick;
    int unsigned       len;
    while (tx_q.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        repeat ($urandom_range(1, 4)) begin
          do b = BYTE_W'($urandom); while (b == cur_start);
          tx_q.push_back(b);
        end
      end else if (pick < 10) begin
        len = $urandom_range(2, 8);
        tx_q.push_back(cur_start);
        tx_q.push_back(BYTE_W'(len));
        repeat ($urandom_range(0, len - 1)) tx_q.push_back(BYTE_W'($urandom));
      end else begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 8);
        payload = {};
        repeat (len)
          payload.push_back(($urandom_range(0, 7) == 0) ?
                            (($urandom_range(0, 1) == 0) ? cur_start : cur_end) :
                            BYTE_W'($urandom));
        crc_xor = (pick < 18 || (pick >= 26 && pick < 30)) ?
                  CRC_W'($urandom_range(1, 16'hFFFF)) : '0;
        end_xor = (pick >= 18 && pick < 30) ? BYTE_W'($urandom_range(1, 255)) : '0;
        add_frame(payload, crc_xor, end_xor);
      end
    end
  endfunction

  task automatic send_bytes();
    int burst_left;
    burst_left = pick_burst();
    while (tx_q.size() != 0) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = pick_burst();
      end
      in_valid   <= 1'b1;
      in_rx_byte <= tx_q.pop_front();
      do @(posedge clk); while (!in_ready);
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value);
    logic [DATA_W-1:0] wdata;
    wdata          = $urandom;
    wdata[7:0]     = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_START_MARKER) begin
      sb.start_marker = value;
      cur_start       = value;
    end else begin
      sb.end_marker = value;
      cur_end       = value;
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] payload[$];
    logic [BYTE_W-1:0] s;
    logic [BYTE_W-1:0] e;
    logic [CRC_W-1:0]  crc;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_rx_byte  <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero length, markers and 0xFF as payload, bad CRC, bad CRC with bad end
    payload = {};
    add_frame(payload, '0, '0);
    payload = '{cur_start, cur_end, 8'hFF};
    add_frame(payload, '0, '0);
    payload = {};
    add_frame(payload, 16'hFFFF, '0);
    add_frame(payload, 16'h8001, cur_end ^ 8'hFF);
    send_bytes();
    settle();

    // end marker changed while a frame is open
    tx_q = '{cur_start, 8'd1, 8'h5A};
    send_bytes();
    settle();
    write_reg(ADDR_END_MARKER, 8'hA5);
    crc  = deframer_scoreboard::crc_step('0, 8'h5A);
    tx_q = '{crc[15:8], crc[7:0], cur_end};
    send_bytes();
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       {s, e} = {8'h00, 8'hFF};
        1:       {s, e} = {8'hFF, 8'h00};
        2:       {s, e} = 16'($urandom);
        3:       {s, e} = {8'h7E, 8'h7E};
        default: {s, e} = {START_RESET, END_RESET};
      endcase
      write_reg(ADDR_START_MARKER, s);
      write_reg(ADDR_END_MARKER, e);
      if (p == 0 || p == 3) begin
        payload = {};
        repeat (LONGEST_LEN) payload.push_back(BYTE_W'($urandom));
        add_frame(payload, '0, '0);
      end
      add_random_traffic(tx_q.size() + PHASE_BYTES);
      if (p == 2) hold_pending = 1'b1;
      send_bytes();
      settle();
    end

    if (sb.error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
